// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define OCMP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ocmp assertion failed");

// Next-cycle implication, disabled while in reset.
`define OCMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ocmp assertion failed");

`endif

// ===== src/ocmp_pkg.sv =====
// ----------------------------------------------------------------------------
// ocmp_pkg
// Shared types and codes of the object carousel message parser.
// ----------------------------------------------------------------------------
package ocmp_pkg;

  localparam int unsigned CfgW = 16;

  // record kinds
  localparam logic [2:0] RK_FILE_HDR = 3'd0;
  localparam logic [2:0] RK_CONTENT  = 3'd1;
  localparam logic [2:0] RK_NAME     = 3'd2;
  localparam logic [2:0] RK_DIR_BIND = 3'd3;
  localparam logic [2:0] RK_GW_BIND  = 3'd4;
  localparam logic [2:0] RK_ABORT    = 3'd5;

  // abort codes
  localparam logic [7:0] AB_MAGIC  = 8'd0;
  localparam logic [7:0] AB_STREAM = 8'd1;
  localparam logic [7:0] AB_STEVT  = 8'd2;
  localparam logic [7:0] AB_UNKN   = 8'd3;
  localparam logic [7:0] AB_LITE   = 8'd4;

  // binding kinds
  localparam logic [1:0] BK_DIR   = 2'd0;
  localparam logic [1:0] BK_FIL   = 2'd1;
  localparam logic [1:0] BK_OTHER = 2'd2;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [7:0]  data_byte;
    logic [31:0] parent_key;
    logic [2:0]  parent_key_len;
    logic [15:0] parent_module;
    logic [31:0] content_length;
    logic [1:0]  bind_kind;
    logic [31:0] target_carousel;
    logic [15:0] target_module;
    logic [31:0] target_key;
    logic [2:0]  target_key_len;
    logic [15:0] assoc_tag;
  } rec_t;

endpackage

// ===== src/object_carousel_message_parser_top.sv =====
// ----------------------------------------------------------------------------
// object_carousel_message_parser_top
// BIOP message parser: module bytes in, file/name/binding/abort records out.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  in      | in_valid_i / in_ready_o    | module_byte_i, module_last_i
//  out     | out_valid_o / out_ready_i  | record_kind_o ... assoc_tag_o
//  cfg     | cfg_we_i                   | cfg_wdata_i (carrier module)
//
// One byte per cycle while in_ready_o is high; each byte gives at most one
// registered record. The parser walks one field step per byte; a two-word
// record queue sits in front of the output; in_ready_o drops only while full.
// Reset needs no clearing pass; a byte with module_last_i restarts the parser.
module object_carousel_message_parser_top #(
  parameter int unsigned KEY_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  module_byte_i,
  input  logic        module_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  record_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] parent_key_o,
  output logic [2:0]  parent_key_len_o,
  output logic [15:0] parent_module_o,
  output logic [31:0] content_length_o,
  output logic [1:0]  bind_kind_o,
  output logic [31:0] target_carousel_o,
  output logic [15:0] target_module_o,
  output logic [31:0] target_key_o,
  output logic [2:0]  target_key_len_o,
  output logic [15:0] assoc_tag_o
);
  import ocmp_pkg::*;

  logic take, rec_valid, space;
  rec_t rec, head;

  assign in_ready_o = space;
  assign take       = in_valid_i && space;

  ocmp_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .take_i(take), .module_byte_i, .module_last_i,
    .rec_valid_o(rec_valid), .rec_o(rec)
  );

  ocmp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(take && rec_valid), .push_rec_i(rec), .space_o(space),
    .out_valid_o, .out_ready_i, .out_rec_o(head)
  );

  assign record_kind_o     = head.record_kind;
  assign data_byte_o       = head.data_byte;
  assign parent_key_o      = head.parent_key;
  assign parent_key_len_o  = head.parent_key_len;
  assign parent_module_o   = head.parent_module;
  assign content_length_o  = head.content_length;
  assign bind_kind_o       = head.bind_kind;
  assign target_carousel_o = head.target_carousel;
  assign target_module_o   = head.target_module;
  assign target_key_o      = head.target_key;
  assign target_key_len_o  = head.target_key_len;
  assign assoc_tag_o       = head.assoc_tag;

endmodule

// ===== src/ocmp_queue.sv =====
// ----------------------------------------------------------------------------
// ocmp_queue
// Two-word record queue between parser and output; head is registered.
// ----------------------------------------------------------------------------
module ocmp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ocmp_pkg::rec_t push_rec_i,
  output logic          space_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ocmp_pkg::rec_t out_rec_o
);
  import ocmp_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign space_o     = (cnt_q != (PtrW+1)'(Depth));
  assign out_rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_rec_i;
    end
  end

endmodule

// ===== src/ocmp_front.sv =====
// ----------------------------------------------------------------------------
// ocmp_front
// Byte-level BIOP field walker: classifies each byte and builds records.
// ----------------------------------------------------------------------------
module ocmp_front #(
  parameter int unsigned KEY_BYTES = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ocmp_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                    take_i,
  input  logic [7:0]              module_byte_i,
  input  logic                    module_last_i,
  output logic                    rec_valid_o,
  output ocmp_pkg::rec_t          rec_o
);
  import ocmp_pkg::*;

  localparam int unsigned KeyLim = (KEY_BYTES < 4) ? KEY_BYTES : 4;

  localparam logic [4:0] ST_MAGIC    = 5'd0;
  localparam logic [4:0] ST_HSKIP    = 5'd1;
  localparam logic [4:0] ST_KEYLEN   = 5'd2;
  localparam logic [4:0] ST_KEY      = 5'd3;
  localparam logic [4:0] ST_KINDLEN  = 5'd4;
  localparam logic [4:0] ST_KIND     = 5'd5;
  localparam logic [4:0] ST_INFOLEN  = 5'd6;
  localparam logic [4:0] ST_INFO     = 5'd7;
  localparam logic [4:0] ST_FBODY    = 5'd8;
  localparam logic [4:0] ST_CONTENT  = 5'd9;
  localparam logic [4:0] ST_DBODY    = 5'd10;
  localparam logic [4:0] ST_NCOUNT   = 5'd11;
  localparam logic [4:0] ST_IDLEN    = 5'd12;
  localparam logic [4:0] ST_ID       = 5'd13;
  localparam logic [4:0] ST_CKLEN    = 5'd14;
  localparam logic [4:0] ST_CKIND    = 5'd15;
  localparam logic [4:0] ST_BTYPE    = 5'd16;
  localparam logic [4:0] ST_TIDLEN   = 5'd17;
  localparam logic [4:0] ST_TID      = 5'd18;
  localparam logic [4:0] ST_PROF     = 5'd19;
  localparam logic [4:0] ST_BODYHDR  = 5'd20;
  localparam logic [4:0] ST_LOC      = 5'd21;
  localparam logic [4:0] ST_MODVER   = 5'd22;
  localparam logic [4:0] ST_TKEYLEN  = 5'd23;
  localparam logic [4:0] ST_TKEY     = 5'd24;
  localparam logic [4:0] ST_BINDER   = 5'd25;
  localparam logic [4:0] ST_TAP      = 5'd26;
  localparam logic [4:0] ST_SELLEN   = 5'd27;
  localparam logic [4:0] ST_SEL      = 5'd28;
  localparam logic [4:0] ST_OINFOLEN = 5'd29;
  localparam logic [4:0] ST_OINFO    = 5'd30;

  localparam logic [31:0] KIND_FIL = 32'h66696C00;
  localparam logic [31:0] KIND_DIR = 32'h64697200;
  localparam logic [31:0] KIND_SRG = 32'h73726700;
  localparam logic [31:0] KIND_STR = 32'h73747200;
  localparam logic [31:0] KIND_STE = 32'h73746500;

  // bytes in a fixed-size field; zero marks a length-driven run
  function automatic logic [3:0] fixed_size(input logic [4:0] st);
    logic [3:0] n;
    unique case (st)
      ST_MAGIC, ST_KINDLEN, ST_TIDLEN, ST_MODVER:           n = 4'd4;
      ST_HSKIP, ST_PROF:                                    n = 4'd8;
      ST_KEYLEN, ST_NCOUNT, ST_IDLEN, ST_CKLEN, ST_BTYPE,
      ST_TKEYLEN, ST_SELLEN:                                n = 4'd1;
      ST_INFOLEN, ST_OINFOLEN:                              n = 4'd2;
      ST_FBODY, ST_LOC:                                     n = 4'd9;
      ST_DBODY:                                             n = 4'd7;
      ST_BODYHDR, ST_BINDER, ST_TAP:                        n = 4'd6;
      default:                                              n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] magic_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h42;
      2'd1: c = 8'h49;
      2'd2: c = 8'h4F;
      default: c = 8'h50;
    endcase
    return c;
  endfunction

  logic [CfgW-1:0] carrier_q;
  logic [4:0]  step_q, step_d;
  logic [31:0] fcount_q, fcount_d;
  logic [2:0]  runpos_q, runpos_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  mkind_q, mkind_d;
  logic [15:0] binds_q, binds_d;
  logic [7:0]  comps_q, comps_d;
  logic [31:0] kind_q, kind_d;
  logic [31:0] ckind_q, ckind_d;
  logic        first_q, first_d;
  logic [31:0] key_q, key_d;
  logic [2:0]  keylen_q, keylen_d;
  logic [31:0] clen_q, clen_d;
  logic [31:0] tcar_q, tcar_d;
  logic [15:0] tmod_q, tmod_d;
  logic [31:0] tkey_q, tkey_d;
  logic [2:0]  tkeylen_q, tkeylen_d;
  logic [15:0] tassoc_q, tassoc_d;
  logic [1:0]  bkind_q, bkind_d;
  logic        drop_q, drop_d;

  logic [3:0]  fsize;
  logic [31:0] acc_new, fc_new, run_len;
  logic        fin, start_run;
  logic [4:0]  fin_st, run_st;
  logic [7:0]  b;

  assign b = module_byte_i;

  always_comb begin
    step_d = step_q; fcount_d = fcount_q; runpos_d = runpos_q; acc_d = acc_q;
    mkind_d = mkind_q; binds_d = binds_q; comps_d = comps_q; kind_d = kind_q;
    ckind_d = ckind_q; first_d = first_q; key_d = key_q; keylen_d = keylen_q;
    clen_d = clen_q; tcar_d = tcar_q; tmod_d = tmod_q; tkey_d = tkey_q;
    tkeylen_d = tkeylen_q; tassoc_d = tassoc_q; bkind_d = bkind_q; drop_d = drop_q;
    rec_valid_o = 1'b0;
    rec_o = '0;
    fin = 1'b0;
    fin_st = step_q;
    start_run = 1'b0;
    run_st = step_q;
    run_len = '0;
    fsize = fixed_size(step_q);
    acc_new = {acc_q[23:0], b};
    fc_new = fcount_q + 32'd1;

    if (take_i && !drop_q) begin
      if (step_q > ST_OINFO) begin
        // out-of-range step: restart at the magic
        step_d = ST_MAGIC; fcount_d = '0; acc_d = '0;
        key_d = '0; keylen_d = '0; kind_d = '0; clen_d = '0;
      end else if (fsize == 4'd0) begin
        if (fcount_q == '0) begin
          fin = 1'b1;
          fin_st = step_q;
        end else begin
          unique case (step_q)
            ST_KEY: begin
              if (runpos_q < 3'(KeyLim)) begin
                key_d[(2'd3 - runpos_q[1:0])*8 +: 8] = b;
                keylen_d = runpos_q + 3'd1;
              end
            end
            ST_KIND: begin
              if (runpos_q < 3'd4) kind_d[(2'd3 - runpos_q[1:0])*8 +: 8] = b;
            end
            ST_CONTENT: begin
              rec_valid_o = 1'b1;
              rec_o.record_kind = RK_CONTENT;
              rec_o.data_byte = b;
              rec_o.parent_key = key_q;
              rec_o.parent_key_len = keylen_q;
              rec_o.content_length = clen_q;
            end
            ST_ID: begin
              rec_valid_o = 1'b1;
              rec_o.record_kind = RK_NAME;
              rec_o.data_byte = b;
              if (mkind_q == 2'd1) begin
                rec_o.parent_key = key_q;
                rec_o.parent_key_len = keylen_q;
                rec_o.parent_module = carrier_q;
              end
            end
            ST_CKIND: begin
              if (runpos_q < 3'd4) ckind_d[(2'd3 - runpos_q[1:0])*8 +: 8] = b;
            end
            ST_TKEY: begin
              if (runpos_q < 3'(KeyLim)) begin
                tkey_d[(2'd3 - runpos_q[1:0])*8 +: 8] = b;
                tkeylen_d = runpos_q + 3'd1;
              end
            end
            default: ;
          endcase
          if (runpos_q != 3'd4) runpos_d = runpos_q + 3'd1;
          fcount_d = fcount_q - 32'd1;
          if (fcount_q == 32'd1) begin
            fin = 1'b1;
            fin_st = step_q;
          end
        end
      end else if (step_q == ST_MAGIC && b != magic_char(fcount_q[1:0])) begin
        rec_valid_o = 1'b1;
        rec_o.record_kind = RK_ABORT;
        rec_o.data_byte = AB_MAGIC;
        drop_d = 1'b1;
      end else begin
        acc_d = acc_new;
        fcount_d = fc_new;
        if (fc_new >= {28'd0, fsize}) begin
          // field complete: move on to the next field or start a run
          fcount_d = '0;
          acc_d = '0;
          unique case (step_q)
            ST_MAGIC:   step_d = ST_HSKIP;
            ST_HSKIP:   step_d = ST_KEYLEN;
            ST_KEYLEN:  begin start_run = 1'b1; run_st = ST_KEY; run_len = {24'd0, b}; end
            ST_KINDLEN: begin
              kind_d = '0;
              start_run = 1'b1; run_st = ST_KIND; run_len = acc_new;
            end
            ST_INFOLEN: begin
              start_run = 1'b1; run_st = ST_INFO; run_len = {16'd0, acc_new[15:0]};
            end
            ST_FBODY: begin
              clen_d = acc_new;
              rec_valid_o = 1'b1;
              rec_o.record_kind = RK_FILE_HDR;
              rec_o.parent_key = key_q;
              rec_o.parent_key_len = keylen_q;
              rec_o.content_length = acc_new;
              start_run = 1'b1; run_st = ST_CONTENT; run_len = acc_new;
            end
            ST_DBODY: begin
              binds_d = acc_new[15:0];
              if (acc_new[15:0] == '0) begin
                step_d = ST_MAGIC;
                key_d = '0; keylen_d = '0; kind_d = '0; clen_d = '0;
              end else begin
                tcar_d = '0; tmod_d = '0; tkey_d = '0; tkeylen_d = '0; tassoc_d = '0;
                bkind_d = BK_OTHER;
                step_d = ST_NCOUNT;
              end
            end
            ST_NCOUNT: begin
              comps_d = b;
              first_d = 1'b1;
              step_d = (b == 8'd0) ? ST_BTYPE : ST_IDLEN;
            end
            ST_IDLEN:   begin start_run = 1'b1; run_st = ST_ID; run_len = {24'd0, b}; end
            ST_CKLEN: begin
              ckind_d = '0;
              start_run = 1'b1; run_st = ST_CKIND; run_len = {24'd0, b};
            end
            ST_BTYPE:   step_d = ST_TIDLEN;
            ST_TIDLEN:  begin start_run = 1'b1; run_st = ST_TID; run_len = acc_new; end
            ST_PROF: begin
              if (acc_new[7:0] == 8'h06) begin
                step_d = ST_BODYHDR;
              end else if (acc_new[7:0] == 8'h05) begin
                rec_valid_o = 1'b1;
                rec_o.record_kind = RK_ABORT;
                rec_o.data_byte = AB_LITE;
                drop_d = 1'b1;
                fcount_d = fc_new;
                acc_d = acc_new;
              end else begin
                step_d = ST_OINFOLEN;
              end
            end
            ST_BODYHDR: step_d = ST_LOC;
            ST_LOC:     begin tcar_d = acc_new; step_d = ST_MODVER; end
            ST_MODVER:  begin tmod_d = acc_new[31:16]; step_d = ST_TKEYLEN; end
            ST_TKEYLEN: begin
              tkey_d = '0; tkeylen_d = '0;
              start_run = 1'b1; run_st = ST_TKEY; run_len = {24'd0, b};
            end
            ST_BINDER:  step_d = ST_TAP;
            ST_TAP:     begin tassoc_d = acc_new[15:0]; step_d = ST_SELLEN; end
            ST_SELLEN:  begin start_run = 1'b1; run_st = ST_SEL; run_len = {24'd0, b}; end
            ST_OINFOLEN: begin
              start_run = 1'b1; run_st = ST_OINFO; run_len = {16'd0, acc_new[15:0]};
            end
            default: begin
              step_d = ST_MAGIC;
              key_d = '0; keylen_d = '0; kind_d = '0; clen_d = '0;
            end
          endcase
          if (start_run) begin
            step_d = run_st;
            fcount_d = run_len;
            runpos_d = '0;
            if (run_len == '0) begin
              fin = 1'b1;
              fin_st = run_st;
            end
          end
        end
      end
    end

    // close a length-driven run
    if (fin) begin
      fcount_d = '0;
      acc_d = '0;
      unique case (fin_st)
        ST_KEY:     step_d = ST_KINDLEN;
        ST_KIND:    step_d = ST_INFOLEN;
        ST_INFO: begin
          if (kind_d == KIND_FIL) begin
            mkind_d = 2'd0; step_d = ST_FBODY;
          end else if (kind_d == KIND_DIR) begin
            mkind_d = 2'd1; step_d = ST_DBODY;
          end else if (kind_d == KIND_SRG) begin
            mkind_d = 2'd2; step_d = ST_DBODY;
          end else begin
            // abort keeps the run position; the block drops bytes from here on
            fcount_d = fcount_q - ((fcount_q == '0) ? 32'd0 : 32'd1);
            fcount_d = '0;
            step_d = fin_st;
            rec_valid_o = 1'b1;
            rec_o = '0;
            rec_o.record_kind = RK_ABORT;
            rec_o.data_byte = (kind_d == KIND_STR) ? AB_STREAM :
                              (kind_d == KIND_STE) ? AB_STEVT : AB_UNKN;
            drop_d = 1'b1;
          end
        end
        ST_CONTENT: begin
          step_d = ST_MAGIC;
          key_d = '0; keylen_d = '0; kind_d = '0; clen_d = '0;
        end
        ST_ID:      step_d = ST_CKLEN;
        ST_CKIND: begin
          if (first_d) begin
            bkind_d = (ckind_d == KIND_DIR) ? BK_DIR :
                      (ckind_d == KIND_FIL) ? BK_FIL : BK_OTHER;
            first_d = 1'b0;
          end
          comps_d = comps_d - 8'd1;
          step_d = (comps_d == 8'd0) ? ST_BTYPE : ST_IDLEN;
        end
        ST_TID:     step_d = ST_PROF;
        ST_TKEY:    step_d = ST_BINDER;
        ST_SEL:     step_d = ST_OINFOLEN;
        default: begin
          rec_valid_o = 1'b1;
          rec_o = '0;
          rec_o.record_kind = (mkind_d == 2'd1) ? RK_DIR_BIND : RK_GW_BIND;
          if (mkind_d == 2'd1) begin
            rec_o.parent_key = key_d;
            rec_o.parent_key_len = keylen_d;
            rec_o.parent_module = carrier_q;
          end
          rec_o.bind_kind = bkind_d;
          rec_o.target_carousel = tcar_d;
          rec_o.target_module = tmod_d;
          rec_o.target_key = tkey_d;
          rec_o.target_key_len = tkeylen_d;
          rec_o.assoc_tag = tassoc_d;
          binds_d = binds_d - 16'd1;
          if (binds_d == '0) begin
            step_d = ST_MAGIC;
            key_d = '0; keylen_d = '0; kind_d = '0; clen_d = '0;
          end else begin
            tcar_d = '0; tmod_d = '0; tkey_d = '0; tkeylen_d = '0; tassoc_d = '0;
            bkind_d = BK_OTHER;
            step_d = ST_NCOUNT;
          end
        end
      endcase
    end

    // last byte of the module: back to the start state
    if (take_i && module_last_i) begin
      step_d = ST_MAGIC; fcount_d = '0; runpos_d = '0; acc_d = '0;
      mkind_d = '0; binds_d = '0; comps_d = '0; kind_d = '0; ckind_d = '0;
      first_d = 1'b0; key_d = '0; keylen_d = '0; clen_d = '0;
      tcar_d = '0; tmod_d = '0; tkey_d = '0; tkeylen_d = '0; tassoc_d = '0;
      bkind_d = '0; drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_q <= '0;
      step_q <= ST_MAGIC; fcount_q <= '0; runpos_q <= '0; acc_q <= '0;
      mkind_q <= '0; binds_q <= '0; comps_q <= '0; kind_q <= '0; ckind_q <= '0;
      first_q <= 1'b0; key_q <= '0; keylen_q <= '0; clen_q <= '0;
      tcar_q <= '0; tmod_q <= '0; tkey_q <= '0; tkeylen_q <= '0; tassoc_q <= '0;
      bkind_q <= '0; drop_q <= 1'b0;
    end else begin
      if (cfg_we_i) carrier_q <= cfg_wdata_i;
      if (take_i) begin
        step_q <= step_d; fcount_q <= fcount_d; runpos_q <= runpos_d; acc_q <= acc_d;
        mkind_q <= mkind_d; binds_q <= binds_d; comps_q <= comps_d; kind_q <= kind_d;
        ckind_q <= ckind_d; first_q <= first_d; key_q <= key_d; keylen_q <= keylen_d;
        clen_q <= clen_d; tcar_q <= tcar_d; tmod_q <= tmod_d; tkey_q <= tkey_d;
        tkeylen_q <= tkeylen_d; tassoc_q <= tassoc_d; bkind_q <= bkind_d;
        drop_q <= drop_d;
      end
    end
  end

endmodule

// ===== src/ocmp_checker.sv =====
// ----------------------------------------------------------------------------
// ocmp_checker
// Port-level checks on the record output of the parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ocmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  record_kind_o,
  input logic [7:0]  data_byte_o,
  input logic [2:0]  parent_key_len_o,
  input logic [15:0] parent_module_o,
  input logic [2:0]  target_key_len_o
);
  import ocmp_pkg::*;

  `OCMP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(record_kind_o))
  `OCMP_ASSERT_NOW(a_kind_range, out_valid_o, record_kind_o != 3'd6 && record_kind_o != 3'd7)
  `OCMP_ASSERT_NOW(a_abort_code, out_valid_o && record_kind_o == RK_ABORT, data_byte_o < 8'd5)
  `OCMP_ASSERT_NOW(a_gw_parent, out_valid_o && record_kind_o == RK_GW_BIND, parent_key_len_o == 3'd0 && parent_module_o == 16'd0)
  `OCMP_ASSERT_NOW(a_key_len, out_valid_o, parent_key_len_o < 3'd5 && target_key_len_o < 3'd5)

endmodule

bind object_carousel_message_parser_top ocmp_checker u_ocmp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .record_kind_o(record_kind_o), .data_byte_o(data_byte_o),
  .parent_key_len_o(parent_key_len_o), .parent_module_o(parent_module_o),
  .target_key_len_o(target_key_len_o)
);

// ===== tb/tb_object_carousel_message_parser_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_object_carousel_message_parser_top
// Sends BIOP modules byte by byte (file, directory and gateway messages, bad
// modules and noise), predicts every record in the testbench and checks each
// record the parser gives, in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_object_carousel_message_parser_top;
  import ocmp_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned KeyBytes = 4;

  // parse steps
  localparam int S_MAGIC = 0, S_HSKIP = 1, S_KEYLEN = 2, S_KEY = 3, S_KINDLEN = 4;
  localparam int S_KIND = 5, S_INFOLEN = 6, S_INFO = 7, S_FBODY = 8, S_CONTENT = 9;
  localparam int S_DBODY = 10, S_NCOUNT = 11, S_IDLEN = 12, S_ID = 13, S_CKLEN = 14;
  localparam int S_CKIND = 15, S_BTYPE = 16, S_TIDLEN = 17, S_TID = 18, S_PROF = 19;
  localparam int S_BODYHDR = 20, S_LOC = 21, S_MODVER = 22, S_TKEYLEN = 23;
  localparam int S_TKEY = 24, S_BINDER = 25, S_TAP = 26, S_SELLEN = 27, S_SEL = 28;
  localparam int S_OINFOLEN = 29, S_OINFO = 30;

  localparam logic [1:0] MK_FILE = 2'd0, MK_DIR = 2'd1, MK_GATE = 2'd2;

  localparam logic [31:0] KIND_FIL = 32'h66696C00, KIND_DIR = 32'h64697200;
  localparam logic [31:0] KIND_SRG = 32'h73726700, KIND_STR = 32'h73747200;
  localparam logic [31:0] KIND_STE = 32'h73746500;
  localparam logic [7:0] TAG_FULL = 8'h06, TAG_LITE = 8'h05;

  localparam int unsigned StepLen[31] = '{4, 8, 1, 0, 4, 0, 2, 0, 9, 0, 7, 1, 1, 0, 1, 0,
                                          1, 4, 0, 8, 6, 9, 4, 1, 0, 6, 6, 1, 0, 2, 0};
  localparam logic [7:0] Magic[4] = '{8'h42, 8'h49, 8'h4F, 8'h50};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i, in_valid_i, in_ready_o, module_last_i, out_valid_o, out_ready_i;
  logic [15:0] cfg_wdata_i;
  logic [7:0]  module_byte_i;
  rec_t        got;

  object_carousel_message_parser_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .module_byte_i, .module_last_i, .out_valid_o, .out_ready_i,
    .record_kind_o(got.record_kind), .data_byte_o(got.data_byte),
    .parent_key_o(got.parent_key), .parent_key_len_o(got.parent_key_len),
    .parent_module_o(got.parent_module), .content_length_o(got.content_length),
    .bind_kind_o(got.bind_kind), .target_carousel_o(got.target_carousel),
    .target_module_o(got.target_module), .target_key_o(got.target_key),
    .target_key_len_o(got.target_key_len), .assoc_tag_o(got.assoc_tag)
  );

  always #5 clk_i = ~clk_i;

  rec_t        expected_records[$];
  logic [7:0]  module_bytes[$];
  int unsigned mismatches = 0, records_seen = 0, bytes_parsed = 0, modules_sent = 0;
  int unsigned kind_seen[6];
  bit          calm = 1'b0;
  int unsigned idle_cycles = 0;

  // parser shadow state
  int          step;
  logic [31:0] cnt, rpos, acc, kbytes, ckind, clen, tcar;
  logic [1:0]  mkind, bkind;
  logic [15:0] bleft, tmod, tassoc, carrier;
  logic [7:0]  cleft;
  logic [63:0] mkey, tkey;
  int unsigned mklen, tklen;
  bit          firstc, drop;
  rec_t        rb;
  bit          rb_have;

  function automatic logic [2:0] sat4(input int unsigned n);
    return (n > 4) ? 3'd4 : 3'(n);
  endfunction

  function void rb_start(input logic [2:0] k, input logic [7:0] d);
    rb = '0;
    rb.record_kind = k;
    rb.data_byte = d;
  endfunction

  function void rb_parent();
    rb.parent_key = mkey[63:32];
    rb.parent_key_len = sat4(mklen);
  endfunction

  function void rb_commit();
    if (!rb_have) begin
      rb_have = 1'b1;
      expected_records.push_back(rb);
    end
  endfunction

  function void enter_fixed(input int s);
    step = s;
    cnt = 0;
    acc = 0;
  endfunction

  function void drop_module(input logic [7:0] code);
    rb_start(RK_ABORT, code);
    rb_commit();
    drop = 1'b1;
  endfunction

  function void msg_done();
    enter_fixed(S_MAGIC);
    mkey = 0;
    mklen = 0;
    kbytes = 0;
    clen = 0;
  endfunction

  function void bind_open();
    tcar = 0;
    tmod = 0;
    tkey = 0;
    tklen = 0;
    tassoc = 0;
    bkind = BK_OTHER;
    enter_fixed(S_NCOUNT);
  endfunction

  function void bind_close();
    rb_start((mkind == MK_DIR) ? RK_DIR_BIND : RK_GW_BIND, 8'd0);
    if (mkind == MK_DIR) begin
      rb_parent();
      rb.parent_module = carrier;
    end
    rb.bind_kind = bkind;
    rb.target_carousel = tcar;
    rb.target_module = tmod;
    rb.target_key = tkey[63:32];
    rb.target_key_len = sat4(tklen);
    rb.assoc_tag = tassoc;
    rb_commit();
    bleft = bleft - 1'b1;
    if (bleft == 0) msg_done();
    else bind_open();
  endfunction

  function void hdr_done();
    if (kbytes == KIND_FIL) begin
      mkind = MK_FILE;
      enter_fixed(S_FBODY);
    end else if (kbytes == KIND_DIR) begin
      mkind = MK_DIR;
      enter_fixed(S_DBODY);
    end else if (kbytes == KIND_SRG) begin
      mkind = MK_GATE;
      enter_fixed(S_DBODY);
    end else if (kbytes == KIND_STR) drop_module(AB_STREAM);
    else if (kbytes == KIND_STE) drop_module(AB_STEVT);
    else drop_module(AB_UNKN);
  endfunction

  function void run_done(input int s);
    case (s)
      S_KEY:     enter_fixed(S_KINDLEN);
      S_KIND:    enter_fixed(S_INFOLEN);
      S_INFO:    hdr_done();
      S_CONTENT: msg_done();
      S_ID:      enter_fixed(S_CKLEN);
      S_CKIND: begin
        if (firstc) begin
          bkind = (ckind == KIND_DIR) ? BK_DIR : ((ckind == KIND_FIL) ? BK_FIL : BK_OTHER);
          firstc = 1'b0;
        end
        cleft = cleft - 1'b1;
        enter_fixed((cleft == 0) ? S_BTYPE : S_IDLEN);
      end
      S_TID:     enter_fixed(S_PROF);
      S_TKEY:    enter_fixed(S_BINDER);
      S_SEL:     enter_fixed(S_OINFOLEN);
      default:   bind_close();
    endcase
  endfunction

  function void run_open(input int s, input logic [31:0] len);
    step = s;
    cnt = len;
    rpos = 0;
    if (len == 0) run_done(s);
  endfunction

  function void run_step(input int s, input logic [7:0] b);
    case (s)
      S_KEY: if (rpos < KeyBytes) begin
        mkey |= 64'(b) << (56 - 8 * rpos);
        mklen = rpos + 1;
      end
      S_KIND: if (rpos < 4) kbytes |= 32'(b) << (24 - 8 * rpos);
      S_CONTENT: begin
        rb_start(RK_CONTENT, b);
        rb_parent();
        rb.content_length = clen;
        rb_commit();
      end
      S_ID: begin
        rb_start(RK_NAME, b);
        if (mkind == MK_DIR) begin
          rb_parent();
          rb.parent_module = carrier;
        end
        rb_commit();
      end
      S_CKIND: if (rpos < 4) ckind |= 32'(b) << (24 - 8 * rpos);
      S_TKEY: if (rpos < KeyBytes) begin
        tkey |= 64'(b) << (56 - 8 * rpos);
        tklen = rpos + 1;
      end
      default: ;
    endcase
    rpos++;
    cnt--;
    if (cnt == 0) run_done(s);
  endfunction

  function void fixed_step(input int s, input logic [7:0] b);
    logic [31:0] a;
    a = acc;
    case (s)
      S_MAGIC:   enter_fixed(S_HSKIP);
      S_HSKIP:   enter_fixed(S_KEYLEN);
      S_KEYLEN:  run_open(S_KEY, 32'(b));
      S_KINDLEN: begin
        kbytes = 0;
        run_open(S_KIND, a);
      end
      S_INFOLEN: run_open(S_INFO, 32'(a[15:0]));
      S_FBODY: begin
        clen = a;
        rb_start(RK_FILE_HDR, 8'd0);
        rb_parent();
        rb.content_length = a;
        rb_commit();
        run_open(S_CONTENT, a);
      end
      S_DBODY: begin
        bleft = a[15:0];
        if (bleft == 0) msg_done();
        else bind_open();
      end
      S_NCOUNT: begin
        cleft = b;
        firstc = 1'b1;
        enter_fixed((b == 0) ? S_BTYPE : S_IDLEN);
      end
      S_IDLEN:   run_open(S_ID, 32'(b));
      S_CKLEN: begin
        ckind = 0;
        run_open(S_CKIND, 32'(b));
      end
      S_BTYPE:   enter_fixed(S_TIDLEN);
      S_TIDLEN:  run_open(S_TID, a);
      S_PROF: begin
        if (a[7:0] == TAG_FULL) enter_fixed(S_BODYHDR);
        else if (a[7:0] == TAG_LITE) drop_module(AB_LITE);
        else enter_fixed(S_OINFOLEN);
      end
      S_BODYHDR: enter_fixed(S_LOC);
      S_LOC: begin
        tcar = a;
        enter_fixed(S_MODVER);
      end
      S_MODVER: begin
        tmod = a[31:16];
        enter_fixed(S_TKEYLEN);
      end
      S_TKEYLEN: begin
        tkey = 0;
        tklen = 0;
        run_open(S_TKEY, 32'(b));
      end
      S_BINDER:  enter_fixed(S_TAP);
      S_TAP: begin
        tassoc = a[15:0];
        enter_fixed(S_SELLEN);
      end
      S_SELLEN:  run_open(S_SEL, 32'(b));
      S_OINFOLEN: run_open(S_OINFO, 32'(a[15:0]));
      default:   msg_done();
    endcase
  endfunction

  function void parser_clear();
    msg_done();
    rpos = 0;
    mkind = MK_FILE;
    bleft = 0;
    cleft = 0;
    ckind = 0;
    firstc = 1'b0;
    tcar = 0;
    tmod = 0;
    tkey = 0;
    tklen = 0;
    tassoc = 0;
    bkind = BK_DIR;
    drop = 1'b0;
  endfunction

  // advance the shadow parser by one accepted word
  function void parse_byte(input logic [7:0] b, input bit last);
    rb_have = 1'b0;
    if (!drop) begin
      bytes_parsed++;
      if (step > S_OINFO) msg_done();
      if (StepLen[step] == 0) begin
        if (cnt == 0) run_done(step);
        else run_step(step, b);
      end else if (step == S_MAGIC && b != Magic[cnt[1:0]]) begin
        drop_module(AB_MAGIC);
      end else begin
        acc = {acc[23:0], b};
        cnt++;
        if (cnt >= StepLen[step]) fixed_step(step, b);
      end
    end
    if (last) parser_clear();
  endfunction

  // ---- module builders
  function void pb(input logic [7:0] b);
    module_bytes.push_back(b);
  endfunction

  function void pw(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) pb(v[8*i +: 8]);
  endfunction

  function void prand(input int n);
    for (int i = 0; i < n; i++) pb(8'($urandom));
  endfunction

  function void add_header(input logic [31:0] kind, input int kindlen, input int keylen);
    int infolen;
    infolen = $urandom_range(0, 2);
    pw({Magic[0], Magic[1], Magic[2], Magic[3]}, 4);
    prand(8);
    pb(8'(keylen));
    prand(keylen);
    pw(kindlen, 4);
    for (int i = 0; i < kindlen; i++) pb((i < 4) ? kind[31 - 8 * i -: 8] : 8'($urandom));
    pw(infolen, 2);
    prand(infolen);
  endfunction

  function void add_file(input int keylen, input int kindlen, input int len);
    add_header(KIND_FIL, kindlen, keylen);
    prand(5);
    pw(len, 4);
    prand(len);
  endfunction

  function void add_binding(input logic [7:0] tag);
    int n, k;
    n = $urandom_range(0, 2);
    pb(8'(n));
    for (int c = 0; c < n; c++) begin
      k = $urandom_range(0, 3);
      pb(8'(k));
      prand(k);
      case ($urandom_range(0, 2))
        0: begin pb(8'd4); pw(KIND_DIR, 4); end
        1: begin pb(8'd4); pw(KIND_FIL, 4); end
        default: begin k = $urandom_range(0, 5); pb(8'(k)); prand(k); end
      endcase
    end
    prand(1);
    k = $urandom_range(0, 2);
    pw(k, 4);
    prand(k);
    prand(3);
    pb(tag);
    if (tag == TAG_FULL) begin
      prand(6 + 5);
      pw($urandom, 4);
      prand(4);
      k = $urandom_range(0, 6);
      pb(8'(k));
      prand(k + 6 + 4);
      pw($urandom_range(0, 65535), 2);
      k = $urandom_range(0, 3);
      pb(8'(k));
      prand(k);
    end
    k = $urandom_range(0, 3);
    pw(k, 2);
    prand(k);
  endfunction

  function logic [7:0] pick_tag();
    logic [7:0] t;
    t = 8'($urandom);
    if ($urandom_range(0, 3) != 0 || t == TAG_LITE) t = TAG_FULL;
    return t;
  endfunction

  function void add_dir(input logic [31:0] kind, input int nb, input int lite_at);
    add_header(kind, 4, $urandom_range(0, 6));
    prand(5);
    pw(nb, 2);
    for (int i = 0; i < nb; i++) add_binding((i == lite_at) ? TAG_LITE : pick_tag());
  endfunction

  // ---- channel tasks; each starts and ends just after a falling edge
  function int unsigned draw_gap();
    return calm ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    module_byte_i <= b;
    module_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    parse_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_module();
    for (int i = 0; i < module_bytes.size(); i++)
      send_byte(module_bytes[i], i == module_bytes.size() - 1);
    module_bytes.delete();
    modules_sent++;
  endtask

  // hold the sender until every record has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_records.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_carrier(input logic [15:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    carrier = v;
  endtask

  // ---- record checker
  initial begin
    rec_t want;
    int unsigned gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      records_seen++;
      if (got.record_kind <= RK_ABORT) kind_seen[got.record_kind]++;
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record %p", got);
      end else begin
        want = expected_records.pop_front();
        if (got.record_kind !== want.record_kind || got.data_byte !== want.data_byte ||
            got.parent_key !== want.parent_key ||
            got.parent_key_len !== want.parent_key_len ||
            got.parent_module !== want.parent_module ||
            got.content_length !== want.content_length ||
            got.bind_kind !== want.bind_kind ||
            got.target_carousel !== want.target_carousel ||
            got.target_module !== want.target_module ||
            got.target_key !== want.target_key ||
            got.target_key_len !== want.target_key_len ||
            got.assoc_tag !== want.assoc_tag) begin
          mismatches++;
          if (mismatches <= 10) $display("record mismatch\n  exp %p\n  got %p", want, got);
        end
      end
      @(negedge clk_i);
    end
  end

  // watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("object_carousel_message_parser_top test failed");
        $finish;
      end
    end
  end

  // ---- tests
  task automatic test_files();
    add_file(0, 4, 0);
    add_file(4, 3, 3);
    send_module();
    add_file(7, 5, 2);
    send_module();
  endtask

  task automatic test_bindings();
    write_carrier(16'hFFFF);
    add_dir(KIND_DIR, 2, -1);
    add_dir(KIND_SRG, 1, -1);
    add_dir(KIND_DIR, 0, -1);
    send_module();
  endtask

  task automatic test_aborts();
    add_file(1, 4, 1);
    pw(32'h42494F51, 4);
    prand(3);
    send_module();
    add_header(KIND_STR, 4, 2);
    send_module();
    add_header(KIND_STE, 4, 0);
    send_module();
    add_header(32'h78797A00, 4, 1);
    send_module();
    add_dir(KIND_SRG, 2, 1);
    send_module();
    drain();
  endtask

  task automatic test_random_modules();
    int n, p;
    while (bytes_parsed < 900) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 2))
          0: write_carrier(16'h0000);
          1: write_carrier(16'hFFFF);
          default: write_carrier(16'($urandom));
        endcase
      end
      if ($urandom_range(0, 19) == 0) begin
        prand($urandom_range(1, 20));
      end else begin
        n = $urandom_range(1, 3);
        for (int m = 0; m < n; m++) begin
          p = $urandom_range(0, 99);
          if (p < 40) add_file($urandom_range(0, 6), $urandom_range(3, 5),
                               $urandom_range(0, 12));
          else if (p < 65) add_dir(KIND_DIR, $urandom_range(0, 3), -1);
          else if (p < 85) add_dir(KIND_SRG, $urandom_range(0, 3), -1);
          else if (p < 88) add_header(KIND_STR, 4, 1);
          else if (p < 91) add_header(KIND_STE, 4, 1);
          else if (p < 94) add_header(32'($urandom), 4, 1);
          else if (p < 97) add_dir(KIND_DIR, 2, $urandom_range(0, 1));
          else begin
            pw({Magic[0], Magic[1], Magic[2], Magic[3]}, 4);
            module_bytes[module_bytes.size() - 1 - $urandom_range(0, 3)] ^= 8'h20;
          end
        end
        // corrupt or cut short now and then
        p = $urandom_range(0, 9);
        if (p == 0)
          module_bytes[$urandom_range(0, module_bytes.size() - 1)] = 8'($urandom);
        else if (p == 1)
          while (module_bytes.size() > 1 && $urandom_range(0, 7) != 0)
            void'(module_bytes.pop_back());
      end
      send_module();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    module_byte_i = '0;
    module_last_i = 1'b0;
    carrier = '0;
    parser_clear();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_files();
    test_bindings();
    test_aborts();
    test_random_modules();
    drain();
    repeat (10) @(negedge clk_i);
    $display("sent %0d modules, %0d bytes parsed, %0d records checked", modules_sent,
             bytes_parsed, records_seen);
    $display("records: hdr %0d content %0d name %0d dir %0d gateway %0d abort %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5]);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("object_carousel_message_parser_top test passed");
    end else begin
      $display("object_carousel_message_parser_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ocmp_pkg.sv
src/ocmp_queue.sv
src/ocmp_front.sv
src/object_carousel_message_parser_top.sv
src/ocmp_checker.sv
tb/tb_object_carousel_message_parser_top.sv
